FILE: src/sobel_gradient_magnitude_sector_core_defines.svh
// Assertion macros shared by the Sobel core.
`ifndef SOBEL_GRADIENT_MAGNITUDE_SECTOR_CORE_DEFINES_SVH
`define SOBEL_GRADIENT_MAGNITUDE_SECTOR_CORE_DEFINES_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define SGMS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge out of reset.
`define SGMS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/sgms_pkg.sv
`default_nettype none

package sgms_pkg;

    // One pixel transfer.
    typedef struct packed {
        logic [7:0] pixel;
        logic       frame_start;
    } t_in;

    // One result transfer.
    typedef struct packed {
        logic [7:0]  magnitude;
        logic [1:0]  sector;
        logic [9:0]  center_col;
        logic [11:0] center_row;
    } t_out;

    localparam logic [1:0] SEC_HORZ = 2'd0;
    localparam logic [1:0] SEC_SAME = 2'd1;
    localparam logic [1:0] SEC_VERT = 2'd2;
    localparam logic [1:0] SEC_OPP  = 2'd3;

    localparam int CFG_W = 11;
    localparam logic [CFG_W-1:0] WIDTH_RESET = 11'd640;
    localparam logic [CFG_W-1:0] WIDTH_MIN   = 11'd3;

    localparam logic [11:0] ROW_MAX = 12'd4095;
    localparam logic [7:0]  MAG_MAX = 8'd255;

    // tan(22.5 deg) and tan(67.5 deg) in unsigned Q32
    localparam int TAN_W = 44;
    localparam logic [TAN_W-1:0] TAN_LO = 44'd1779033704;
    localparam logic [TAN_W-1:0] TAN_HI = 44'd10368968296;

endpackage

`default_nettype wire

FILE: src/sobel_gradient_magnitude_sector_core.sv
// A pixel passes stage 1, stage 2, stage 3, stage 4 and the result register in turn.
// Throughput: one pixel per cycle unless the sink stalls; the line-store read of one
// cycle and the write-back of the next overlap, with forwarding when both hit one column.
// Results appear only for interior pixels (row >= 2 and column >= 2).
// Reset clears counters, window, pipeline valids and sets image width to 640;
// line stores are not cleared and need no clearing pass.
`default_nettype none

`include "sobel_gradient_magnitude_sector_core_defines.svh"

module sobel_gradient_magnitude_sector_core #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_wr_en,
    input  wire  [sgms_pkg::CFG_W-1:0]    i_cfg_wr_data,
    input  wire                           i_in_valid,
    output logic                          o_in_stall,
    input  sgms_pkg::t_in                 i_in,
    output logic                          o_out_valid,
    input  wire                           i_out_stall,
    output sgms_pkg::t_out                o_out
);

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int CMPW = CW + 12;

    // ------------------------------------------------------------------
    // Pipeline advance: every stage moves together unless the result
    // register holds a transfer that the sink stalls.
    // ------------------------------------------------------------------
    logic w_en;
    logic w_acc;

    assign w_en       = !(o_out_valid && i_out_stall);
    assign o_in_stall = !w_en;
    assign w_acc      = i_in_valid && w_en;

    // ------------------------------------------------------------------
    // Configuration and raster counters
    // ------------------------------------------------------------------
    logic [sgms_pkg::CFG_W-1:0] r_width;
    logic [CW-1:0]              r_col;
    logic [11:0]                r_row;

    logic [CW-1:0]   w_col_now;
    logic [11:0]     w_row_now;
    logic [CMPW-1:0] w_eff;
    logic [CMPW-1:0] w_col_inc;
    logic            w_wrap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= sgms_pkg::WIDTH_RESET;
        end else if (i_cfg_wr_en) begin
            r_width <= i_cfg_wr_data;
        end
    end

    // Frame start clears both counters ahead of this pixel.
    assign w_col_now = i_in.frame_start ? '0 : r_col;
    assign w_row_now = i_in.frame_start ? '0 : r_row;

    // Clamp the programmed width to [3, MAX_WIDTH].
    always_comb begin
        if (r_width < sgms_pkg::WIDTH_MIN) begin
            w_eff = CMPW'(sgms_pkg::WIDTH_MIN);
        end else if (CMPW'(r_width) > CMPW'(MAX_WIDTH)) begin
            w_eff = CMPW'(MAX_WIDTH);
        end else begin
            w_eff = CMPW'(r_width);
        end
    end

    assign w_col_inc = CMPW'(w_col_now) + CMPW'(1);
    assign w_wrap    = (w_col_inc >= w_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_acc) begin
            if (w_wrap) begin
                r_col <= '0;
                if (w_row_now < sgms_pkg::ROW_MAX) begin
                    r_row <= w_row_now + 12'd1;
                end else begin
                    r_row <= w_row_now;
                end
            end else begin
                r_col <= w_col_inc[CW-1:0];
                r_row <= w_row_now;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: line-store read issued at the transfer, data back here.
    // line store A keeps row r-2, line store B keeps row r-1.
    // ------------------------------------------------------------------
    logic [7:0] mem_a [MAX_WIDTH];
    logic [7:0] mem_b [MAX_WIDTH];

    logic          r_v1;
    logic [7:0]    r_p1;
    logic [CW-1:0] r_c1;
    logic [11:0]   r_r1;
    logic [7:0]    r_rd_a;
    logic [7:0]    r_rd_b;

    // Forwarding: the item leaving stage 1 writes the column that the
    // incoming item reads in the same cycle.
    logic       r_fwd;
    logic [7:0] r_fwd_a;
    logic [7:0] r_fwd_b;

    logic [7:0] w_top;
    logic [7:0] w_mid;
    logic [7:0] w_bot;
    logic       w_s1_go;

    assign w_s1_go = w_en && r_v1;
    assign w_top   = r_fwd ? r_fwd_a : r_rd_a;
    assign w_mid   = r_fwd ? r_fwd_b : r_rd_b;
    assign w_bot   = r_p1;

    always_ff @(posedge i_clk) begin
        if (w_s1_go) begin
            mem_a[r_c1] <= w_mid;
        end
        if (w_acc) begin
            r_rd_a <= mem_a[w_col_now];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_go) begin
            mem_b[r_c1] <= w_bot;
        end
        if (w_acc) begin
            r_rd_b <= mem_b[w_col_now];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_fwd <= 1'b0;
        end else if (w_en) begin
            r_v1  <= w_acc;
            r_fwd <= w_acc && r_v1 && (w_col_now == r_c1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_p1    <= i_in.pixel;
            r_c1    <= w_col_now;
            r_r1    <= w_row_now;
            r_fwd_a <= w_mid;
            r_fwd_b <= w_bot;
        end
    end

    // Window: entries 0..2 hold column c-2 (top, mid, bottom), 3..5 column c-1.
    logic [7:0] r_win [6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (w_s1_go) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= w_top;
            r_win[4] <= w_mid;
            r_win[5] <= w_bot;
        end
    end

    // Gradients: gx = left - right, gy = up - down, all weights 1,2,1.
    logic [9:0] w_left;
    logic [9:0] w_right;
    logic [9:0] w_up;
    logic [9:0] w_down;
    logic [9:0] w_ax;
    logic [9:0] w_ay;
    logic       w_interior;

    assign w_left  = 10'(r_win[0]) + {1'b0, r_win[1], 1'b0} + 10'(r_win[2]);
    assign w_right = 10'(w_top) + {1'b0, w_mid, 1'b0} + 10'(w_bot);
    assign w_up    = 10'(r_win[0]) + {1'b0, r_win[3], 1'b0} + 10'(w_top);
    assign w_down  = 10'(r_win[2]) + {1'b0, r_win[5], 1'b0} + 10'(w_bot);

    assign w_ax = (w_left >= w_right) ? (w_left - w_right) : (w_right - w_left);
    assign w_ay = (w_up >= w_down) ? (w_up - w_down) : (w_down - w_up);

    assign w_interior = (r_r1 >= 12'd2) && (r_c1 >= CW'(2));

    // ------------------------------------------------------------------
    // Stage 2: absolute gradients and sign flags
    // ------------------------------------------------------------------
    logic        r_v2;
    logic [9:0]  r_ax2;
    logic [9:0]  r_ay2;
    logic        r_gxz2;
    logic        r_same2;
    logic [9:0]  r_ccol2;
    logic [11:0] r_crow2;

    logic [CW+9:0] w_ccol_ext;

    assign w_ccol_ext = {10'd0, r_c1 - CW'(1)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= r_v1 && w_interior;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_go) begin
            r_ax2   <= w_ax;
            r_ay2   <= w_ay;
            r_gxz2  <= (w_left == w_right);
            r_same2 <= ((w_left > w_right) == (w_up > w_down));
            r_ccol2 <= w_ccol_ext[9:0];
            r_crow2 <= r_r1 - 12'd1;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: squared magnitude and direction sector
    // ------------------------------------------------------------------
    logic [19:0]              w_ax_sq;
    logic [19:0]              w_ay_sq;
    logic [sgms_pkg::TAN_W-1:0] w_ay_q32;
    logic [sgms_pkg::TAN_W-1:0] w_lo_lim;
    logic [sgms_pkg::TAN_W-1:0] w_hi_lim;
    logic [1:0]               w_sec;

    assign w_ax_sq  = 20'(r_ax2) * 20'(r_ax2);
    assign w_ay_sq  = 20'(r_ay2) * 20'(r_ay2);
    assign w_ay_q32 = sgms_pkg::TAN_W'(r_ay2) << 32;
    assign w_lo_lim = sgms_pkg::TAN_LO * sgms_pkg::TAN_W'(r_ax2);
    assign w_hi_lim = sgms_pkg::TAN_HI * sgms_pkg::TAN_W'(r_ax2);

    // A zero gx is vertical; otherwise bin by the tan thresholds, then sign.
    always_comb begin
        if (r_gxz2) begin
            w_sec = sgms_pkg::SEC_VERT;
        end else if (w_ay_q32 < w_lo_lim) begin
            w_sec = sgms_pkg::SEC_HORZ;
        end else if (w_ay_q32 >= w_hi_lim) begin
            w_sec = sgms_pkg::SEC_VERT;
        end else if (r_same2) begin
            w_sec = sgms_pkg::SEC_SAME;
        end else begin
            w_sec = sgms_pkg::SEC_OPP;
        end
    end

    logic        r_v3;
    logic [20:0] r_sq3;
    logic [1:0]  r_sec3;
    logic [9:0]  r_ccol3;
    logic [11:0] r_crow3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_v2) begin
            r_sq3   <= 21'(w_ax_sq) + 21'(w_ay_sq);
            r_sec3  <= w_sec;
            r_ccol3 <= r_ccol2;
            r_crow3 <= r_crow2;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: upper four bits of the saturating integer square root
    // ------------------------------------------------------------------
    // Shift-subtract root over a 16-bit radicand, four result bits a call.
    // Returns the remainder in the upper half and the partial root below.
    function automatic logic [31:0] f_root_half(input logic [15:0] op_in,
                                                input logic [15:0] res_in,
                                                input logic [15:0] one_in);
        logic [15:0] op;
        logic [15:0] res;
        logic [15:0] one;
        logic [15:0] trial;
        op  = op_in;
        res = res_in;
        one = one_in;
        for (int i = 0; i < 4; i++) begin
            trial = res + one;
            if (op >= trial) begin
                op  = op - trial;
                res = (res >> 1) + one;
            end else begin
                res = res >> 1;
            end
            one = one >> 2;
        end
        return {op, res};
    endfunction

    logic [31:0] w_root_hi;
    logic [31:0] w_root_lo;

    logic        r_v4;
    logic        r_sat4;
    logic [15:0] r_op4;
    logic [15:0] r_res4;
    logic [1:0]  r_sec4;
    logic [9:0]  r_ccol4;
    logic [11:0] r_crow4;

    assign w_root_hi = f_root_half(r_sq3[15:0], 16'd0, 16'h4000);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_v3) begin
            r_sat4  <= (r_sq3[20:16] != 5'd0);
            r_op4   <= w_root_hi[31:16];
            r_res4  <= w_root_hi[15:0];
            r_sec4  <= r_sec3;
            r_ccol4 <= r_ccol3;
            r_crow4 <= r_crow3;
        end
    end

    // ------------------------------------------------------------------
    // Output register: lower four root bits and saturation
    // ------------------------------------------------------------------
    logic           r_out_v;
    sgms_pkg::t_out r_out;

    assign w_root_lo = f_root_half(r_op4, r_res4, 16'h0040);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_v4) begin
            r_out.magnitude  <= r_sat4 ? sgms_pkg::MAG_MAX : w_root_lo[7:0];
            r_out.sector     <= r_sec4;
            r_out.center_col <= r_ccol4;
            r_out.center_row <= r_crow4;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SGMS_ASSERT_NOW(a_fwd_has_item, r_fwd, r_v1, "forward flag set with stage 1 empty")
    `SGMS_ASSERT_NEXT(a_frame_origin, w_acc && i_in.frame_start,
        r_v1 && r_c1 == '0 && r_r1 == '0, "frame start did not land at row 0 column 0")
    `SGMS_ASSERT_NEXT(a_edge_no_result, w_s1_go && !w_interior, !r_v2,
        "border pixel produced a result")
    `SGMS_ASSERT_NEXT(a_gx_zero_vert, w_en && r_v2 && r_gxz2,
        r_v3 && r_sec3 == sgms_pkg::SEC_VERT, "zero gx not vertical")

endmodule

`default_nettype wire

FILE: tb/sobel_gradient_magnitude_sector_core_tb.sv
module sobel_gradient_magnitude_sector_core_tb;
    import sgms_pkg::*;

    localparam int MAX_W         = 1024;
    localparam int RANDOM_ITEMS  = 1026;
    // Give pixels that make no result time to land in the line stores.
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int MAX_REPORTS   = 10;

    // Keeps a private copy of the line stores, window and counters, computes the
    // gradient result for every accepted interior pixel and checks the results in order.
    class gradient_scoreboard;
        bit [7:0]       line_two_up [MAX_W];
        bit [7:0]       line_one_up [MAX_W];
        bit [7:0]       win [6];
        int             col_pos;
        int             row_pos;
        bit [CFG_W-1:0] width_reg;
        t_out           expected_grads [$];
        int             faults;

        function new();
            width_reg = WIDTH_RESET;
            col_pos   = 0;
            row_pos   = 0;
            faults    = 0;
        endfunction

        static function int clamp_width(int w);
            if (w < int'(WIDTH_MIN)) return int'(WIDTH_MIN);
            if (w > MAX_W) return MAX_W;
            return w;
        endfunction

        static function int floor_root_sat(int v);
            int r;
            r = 0;
            if (v >= 65536) return int'(MAG_MAX);
            while ((r + 1) * (r + 1) <= v) r++;
            return r;
        endfunction

        static function logic [1:0] canny_sector(int gx, int gy);
            longint unsigned ax, ay, lo, hi;
            lo = 64'(TAN_LO);
            hi = 64'(TAN_HI);
            if (gx == 0) return SEC_VERT;
            ax = 64'((gx < 0) ? -gx : gx);
            ay = 64'((gy < 0) ? -gy : gy);
            if ((ay << 32) < lo * ax) return SEC_HORZ;
            if ((ay << 32) >= hi * ax) return SEC_VERT;
            return ((gx > 0) == (gy > 0)) ? SEC_SAME : SEC_OPP;
        endfunction

        function void take_pixel(t_in px);
            int   c, top, mid, bot, left, right, up, down, gx, gy;
            t_out res;
            if (px.frame_start) begin
                col_pos = 0;
                row_pos = 0;
            end
            c   = col_pos;
            top = int'(line_two_up[c]);
            mid = int'(line_one_up[c]);
            bot = int'(px.pixel);
            if (row_pos >= 2 && c >= 2) begin
                left  = int'(win[0]) + 2 * int'(win[1]) + int'(win[2]);
                right = top + 2 * mid + bot;
                up    = int'(win[0]) + 2 * int'(win[3]) + top;
                down  = int'(win[2]) + 2 * int'(win[5]) + bot;
                gx    = left - right;
                gy    = up - down;
                res.magnitude  = 8'(floor_root_sat(gx * gx + gy * gy));
                res.sector     = canny_sector(gx, gy);
                res.center_col = 10'(c - 1);
                res.center_row = 12'(row_pos - 1);
                expected_grads.push_back(res);
            end
            win[0] = win[3];
            win[1] = win[4];
            win[2] = win[5];
            win[3] = 8'(top);
            win[4] = 8'(mid);
            win[5] = 8'(bot);
            line_two_up[c] = 8'(mid);
            line_one_up[c] = 8'(bot);
            if (c + 1 >= clamp_width(int'(width_reg))) begin
                col_pos = 0;
                if (row_pos < int'(ROW_MAX)) row_pos++;
            end else begin
                col_pos = c + 1;
            end
        endfunction

        function void note_fault(string what, t_out exp, t_out got);
            faults++;
            if (faults <= MAX_REPORTS)
                $display({"%s: expected mag=%0d sec=%0d col=%0d row=%0d,",
                          " got mag=%0d sec=%0d col=%0d row=%0d"},
                         what, exp.magnitude, exp.sector, exp.center_col, exp.center_row,
                         got.magnitude, got.sector, got.center_col, got.center_row);
        endfunction

        function void check_result(t_out got);
            t_out exp;
            if (expected_grads.size() == 0) begin
                note_fault("result with nothing pending", '0, got);
            end else begin
                exp = expected_grads.pop_front();
                if (got.magnitude !== exp.magnitude || got.sector !== exp.sector ||
                    got.center_col !== exp.center_col || got.center_row !== exp.center_row)
                    note_fault("result mismatch", exp, got);
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n       = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic             in_valid    = 1'b0;
    t_in              in_data     = '0;
    logic             out_stall   = 1'b0;
    logic             in_stall;
    logic             out_valid;
    t_out             dut_out;

    gradient_scoreboard sb = new();
    int cycles = 0;
    int random_sent = 0;

    sobel_gradient_magnitude_sector_core #(
        .MAX_WIDTH(MAX_W)
    ) i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_in         (in_data),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_out        (dut_out)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs or drops results.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Check every result transfer against the oldest pending expectation.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_result(dut_out);
    end

    // Output backpressure: long open stretches, short flickers and a few long stalls.
    initial begin
        int len;
        int r;
        @(posedge clk);
        forever begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                out_stall <= 1'b0;
                len = $urandom_range(50, 200);
            end else if (r < 60) begin
                out_stall <= 1'b0;
                len = $urandom_range(1, 4);
            end else if (r < 95) begin
                out_stall <= 1'b1;
                len = $urandom_range(1, 3);
            end else begin
                out_stall <= 1'b1;
                len = $urandom_range(10, 30);
            end
            repeat (len) @(posedge clk);
        end
    end

    // Sender idle time: mostly none, some short gaps, a few long ones.
    function automatic int pick_gap(bit burst);
        int r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Mostly narrow images so that many rows (and results) fit in the budget;
    // values below the minimum exercise the clamp.
    function automatic int pick_width();
        int r;
        r = $urandom_range(0, 99);
        if (r < 7) return $urandom_range(0, 2);
        if (r < 77) return $urandom_range(3, 8);
        if (r < 97) return $urandom_range(9, 40);
        return $urandom_range(41, 100);
    endfunction

    // Content styles: uniform noise, hard black/white edges, low contrast around a base.
    function automatic logic [7:0] pick_pixel(int mode, logic [7:0] base);
        int v;
        case (mode)
            1: begin
                return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            end
            2: begin
                v = int'(base) + int'($urandom_range(0, 15)) - 8;
                if (v < 0) v = 0;
                if (v > 255) v = 255;
                return v[7:0];
            end
            default: begin
                return 8'($urandom_range(0, 255));
            end
        endcase
    endfunction

    // Present one pixel, hold it until the transfer, then predict its result.
    task automatic push_pixel(t_in px, int gap);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        do @(posedge clk); while (in_stall);
        sb.take_pixel(px);
    endtask

    // Send one frame: frame_start on the first pixel, optionally stray restarts inside.
    task automatic stream_frame(int n_items, int mode, bit burst, bit noisy);
        t_in        px;
        logic [7:0] base;
        base = 8'($urandom_range(0, 255));
        for (int k = 0; k < n_items; k++) begin
            px.pixel       = pick_pixel(mode, base);
            px.frame_start = (k == 0) || (noisy && $urandom_range(0, 49) == 0);
            push_pixel(px, pick_gap(burst));
        end
    endtask

    // Stop sending, wait for every pending result, then let the pipeline go quiet.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_grads.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the width register while idle; the next frame always starts fresh.
    task automatic write_width(int w);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w[CFG_W-1:0];
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.width_reg = w[CFG_W-1:0];
    endtask

    initial begin
        // Flat field, vertical step up, then edges that land in the vertical,
        // same-sign diagonal and horizontal sectors, with saturated magnitudes.
        byte unsigned directed_px [24] = '{
            0, 0, 0,   0, 0, 0,   0, 0, 0,
            255, 255, 255,   255, 255, 255,
            255, 0, 0,   255, 0, 0,   255, 0, 0
        };
        t_in px;
        int  w;
        int  n;
        int  rows;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_width(int'(WIDTH_MIN));
        foreach (directed_px[k]) begin
            px.pixel       = directed_px[k];
            px.frame_start = (k == 0);
            push_pixel(px, pick_gap(1'b0));
        end
        drain();

        // Random frames: mostly whole frames, some cut short, some with stray restarts.
        while (random_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 4) begin
                drain();
                write_width(pick_width());
            end else if ($urandom_range(0, 7) == 0) begin
                drain();
            end
            w    = gradient_scoreboard::clamp_width(int'(sb.width_reg));
            rows = (w > 40) ? 3 : $urandom_range(3, 7);
            n    = rows * w;
            if ($urandom_range(0, 99) < 15) n = $urandom_range(1, n - 1);
            if (n > RANDOM_ITEMS - random_sent) n = RANDOM_ITEMS - random_sent;
            stream_frame(n, $urandom_range(0, 2), $urandom_range(0, 3) == 0,
                         $urandom_range(0, 9) == 0);
            random_sent += n;
        end

        drain();
        if (sb.faults == 0 && sb.expected_grads.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
